// ===== src/ucma_pkg.sv =====
// ----------------------------------------------------------------------------
// ucma_pkg
// Shared types, constants and fixed-point helpers for the upwind momentum
// coefficient assembly unit (signed Q16.16 arithmetic with saturation).
// ----------------------------------------------------------------------------
package ucma_pkg;

	// register widths
	localparam int RECIP_W = 31;
	localparam int RELAX_W = 17;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 3;

	// register reset values
	localparam logic [RECIP_W-1:0] INV_DENSITY_RST   = 31'd65536;
	localparam logic [RECIP_W-1:0] INV_TIME_STEP_RST = 31'd65536;
	localparam logic [RELAX_W-1:0] RELAX_FACTOR_RST  = 17'd45875;
	localparam logic [RECIP_W-1:0] INV_RELAX_RST     = 31'd93623;

	// one in Q16.16, as an 18 bit signed value
	localparam logic signed [17:0] Q_ONE = 18'sd65536;

	// register index codes
	typedef enum logic [INDEX_W-1:0] {
		REG_INV_DENSITY   = 3'd0,
		REG_INV_TIME_STEP = 3'd1,
		REG_RELAX_FACTOR  = 3'd2,
		REG_INV_RELAX     = 3'd3
	} reg_idx_t;

	// configuration values seen by the datapath
	typedef struct packed {
		logic [RECIP_W-1:0] inv_density;
		logic [RECIP_W-1:0] inv_time_step;
		logic [RELAX_W-1:0] relax_factor;
		logic [RECIP_W-1:0] inv_relax_factor;
	} cfg_t;

	// saturate a 36 bit signed sum to 32 bits
	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// round a Q32.32 product to Q16.16 (half up, floor) and saturate
	function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
		logic signed [63:0] q;
		logic signed [47:0] f;
		logic signed [31:0] r;
		q = p + 64'sd32768;
		f = q[63:16];
		if (f > 48'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (f < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = f[31:0];
		return r;
	endfunction

endpackage

// ===== src/upwind_momentum_coefficient_assembly_unit.sv =====
// ----------------------------------------------------------------------------
// upwind_momentum_coefficient_assembly_unit
// Assembles first-order upwind momentum matrix coefficients and the source
// term for one finite-volume cell per item, in signed Q16.16.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | face dif/mdot, cell_volume, velocity, grad
//  out      | out_valid / out_stall| coef_east..south, coef_center, source_term
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled; six register stages
//  hold a chain of four dependent multiplies (volume by time step, center,
//  relaxation, velocity), each followed by its own register.
//  Reset clears the stage valid bits and loads the register defaults.
//  A stalled output item freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module upwind_momentum_coefficient_assembly_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           dif_east,
	input  logic signed [31:0]           dif_west,
	input  logic signed [31:0]           dif_north,
	input  logic signed [31:0]           dif_south,
	input  logic signed [31:0]           mdot_east,
	input  logic signed [31:0]           mdot_west,
	input  logic signed [31:0]           mdot_north,
	input  logic signed [31:0]           mdot_south,
	input  logic [30:0]                  cell_volume,
	input  logic signed [31:0]           velocity,
	input  logic signed [31:0]           grad_times_vol,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           coef_east,
	output logic signed [31:0]           coef_west,
	output logic signed [31:0]           coef_north,
	output logic signed [31:0]           coef_south,
	output logic signed [31:0]           coef_center,
	output logic signed [31:0]           source_term,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ucma_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ucma_pkg::DATA_W-1:0]  cfg_data
);
	import ucma_pkg::*;

	localparam int STAGES = 6;

	cfg_t              cfg;
	logic              adv;
	logic [STAGES-1:0] vld_q;

	// pipeline moves unless a finished item is held at the output
	assign adv       = !(vld_q[STAGES-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[STAGES-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[STAGES-2:0], in_valid};
	end

	ucma_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ucma_datapath u_dp (
		.clk            (clk),
		.adv            (adv),
		.cfg            (cfg),
		.dif_east       (dif_east),
		.dif_west       (dif_west),
		.dif_north      (dif_north),
		.dif_south      (dif_south),
		.mdot_east      (mdot_east),
		.mdot_west      (mdot_west),
		.mdot_north     (mdot_north),
		.mdot_south     (mdot_south),
		.cell_volume    (cell_volume),
		.velocity       (velocity),
		.grad_times_vol (grad_times_vol),
		.coef_east      (coef_east),
		.coef_west      (coef_west),
		.coef_north     (coef_north),
		.coef_south     (coef_south),
		.coef_center    (coef_center),
		.source_term    (source_term)
	);

endmodule

// ===== src/ucma_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ucma_cfg_regs
// Configuration register file: density, time step and relaxation values,
// written through a simple valid/ready port, always ready.
// ----------------------------------------------------------------------------
module ucma_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ucma_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ucma_pkg::DATA_W-1:0]  cfg_data,
	output ucma_pkg::cfg_t               cfg
);
	import ucma_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_density      <= INV_DENSITY_RST;
			cfg_q.inv_time_step    <= INV_TIME_STEP_RST;
			cfg_q.relax_factor     <= RELAX_FACTOR_RST;
			cfg_q.inv_relax_factor <= INV_RELAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_DENSITY:   cfg_q.inv_density      <= cfg_data[RECIP_W-1:0];
				REG_INV_TIME_STEP: cfg_q.inv_time_step    <= cfg_data[RECIP_W-1:0];
				REG_RELAX_FACTOR:  cfg_q.relax_factor     <= cfg_data[RELAX_W-1:0];
				REG_INV_RELAX:     cfg_q.inv_relax_factor <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/ucma_datapath.sv =====
// ----------------------------------------------------------------------------
// ucma_datapath
// Six-stage coefficient datapath: upwind split, volume products, center
// coefficient, relaxation and source term. All stages load on adv.
// ----------------------------------------------------------------------------
module ucma_datapath (
	input  logic                 clk,
	input  logic                 adv,
	input  ucma_pkg::cfg_t       cfg,
	input  logic signed [31:0]   dif_east,
	input  logic signed [31:0]   dif_west,
	input  logic signed [31:0]   dif_north,
	input  logic signed [31:0]   dif_south,
	input  logic signed [31:0]   mdot_east,
	input  logic signed [31:0]   mdot_west,
	input  logic signed [31:0]   mdot_north,
	input  logic signed [31:0]   mdot_south,
	input  logic [30:0]          cell_volume,
	input  logic signed [31:0]   velocity,
	input  logic signed [31:0]   grad_times_vol,
	output logic signed [31:0]   coef_east,
	output logic signed [31:0]   coef_west,
	output logic signed [31:0]   coef_north,
	output logic signed [31:0]   coef_south,
	output logic signed [31:0]   coef_center,
	output logic signed [31:0]   source_term
);
	import ucma_pkg::*;

	logic signed [31:0] dif [4];
	logic signed [31:0] mdot [4];
	logic signed [31:0] nb_c [4];
	logic signed [35:0] sum_dif_c, sum_out_c;
	logic signed [31:0] vol_c, irf_c, its_c, idens_c;

	// stage registers
	logic signed [31:0] nb_s1 [4], nb_s2 [4], nb_s3 [4], nb_s4 [4], nb_s5 [4];
	logic signed [35:0] net_s1;
	logic signed [63:0] p_vt_s1, p_vv_s1, p_gd_s1;
	logic signed [31:0] vel_s1, vel_s2, vel_s3, vel_s4;
	logic signed [31:0] s_s2, vv_s2, gd_s2, gd_s3, gd_s4, gd_s5;
	logic signed [63:0] p_c_s3, p_t3_s3;
	logic signed [31:0] center_s4, center_s5, t3_s4, t3_s5;
	logic signed [63:0] p_omc_s4, p_t2_s5;
	logic signed [31:0] center_c, omc_c, t2_c;
	logic signed [17:0] om_c;
	logic signed [35:0] src_sum_c;

	assign dif[0]  = dif_east;
	assign dif[1]  = dif_west;
	assign dif[2]  = dif_north;
	assign dif[3]  = dif_south;
	assign mdot[0] = mdot_east;
	assign mdot[1] = mdot_west;
	assign mdot[2] = mdot_north;
	assign mdot[3] = mdot_south;

	assign vol_c   = signed'({1'b0, cell_volume});
	assign its_c   = signed'({1'b0, cfg.inv_time_step});
	assign irf_c   = signed'({1'b0, cfg.inv_relax_factor});
	assign idens_c = signed'({1'b0, cfg.inv_density});

	// upwind split: inflow joins neighbors, outflow joins the center
	always_comb begin
		sum_dif_c = '0;
		sum_out_c = '0;
		for (int k = 0; k < 4; k++) begin
			nb_c[k] = sat36(36'(dif[k]) + ((mdot[k] < 0) ? 36'(mdot[k]) : 36'sd0));
			sum_dif_c = sum_dif_c + 36'(dif[k]);
			sum_out_c = sum_out_c + ((mdot[k] > 0) ? 36'(mdot[k]) : 36'sd0);
		end
	end

	// stage 1: neighbors, net flux sum, raw volume and pressure products
	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s1   <= nb_c;
			net_s1  <= sum_out_c - sum_dif_c;
			p_vt_s1 <= 64'(vol_c) * 64'(its_c);
			p_vv_s1 <= 64'(velocity) * 64'(vol_c);
			p_gd_s1 <= 64'(idens_c) * 64'(grad_times_vol);
			vel_s1  <= velocity;
		end
	end

	// stage 2: unrelaxed center sum, rounded velocity and pressure products
	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s2  <= nb_s1;
			s_s2   <= sat36(net_s1 + 36'(rnd_sat(p_vt_s1)));
			vv_s2  <= rnd_sat(p_vv_s1);
			gd_s2  <= rnd_sat(p_gd_s1);
			vel_s2 <= vel_s1;
		end
	end

	// stage 3: relaxation scaling and transient product
	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s3   <= nb_s2;
			p_c_s3  <= 64'(s_s2) * 64'(irf_c);
			p_t3_s3 <= 64'(vv_s2) * 64'(its_c);
			gd_s3   <= gd_s2;
			vel_s3  <= vel_s2;
		end
	end

	// stage 4: center coefficient, times one minus lambda
	assign center_c = rnd_sat(p_c_s3);
	assign om_c     = Q_ONE - signed'({1'b0, cfg.relax_factor});

	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s4     <= nb_s3;
			center_s4 <= center_c;
			p_omc_s4  <= 64'(om_c) * 64'(center_c);
			t3_s4     <= rnd_sat(p_t3_s3);
			gd_s4     <= gd_s3;
			vel_s4    <= vel_s3;
		end
	end

	// stage 5: relaxation part times velocity
	assign omc_c = rnd_sat(p_omc_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s5     <= nb_s4;
			center_s5 <= center_s4;
			p_t2_s5   <= 64'(omc_c) * 64'(vel_s4);
			t3_s5     <= t3_s4;
			gd_s5     <= gd_s4;
		end
	end

	// stage 6: source term sum and output register
	assign t2_c      = rnd_sat(p_t2_s5);
	assign src_sum_c = 36'(t2_c) + 36'(t3_s5) - 36'(gd_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_east   <= nb_s5[0];
			coef_west   <= nb_s5[1];
			coef_north  <= nb_s5[2];
			coef_south  <= nb_s5[3];
			coef_center <= center_s5;
			source_term <= sat36(src_sum_c);
		end
	end

endmodule
